// ===== rtl/scdec_pkg.sv =====
// ---------------------------------------------------------------------------
// Scancode decoder package
// Shared types, scancode constants and US layout lookup tables for the
// set-1 scancode to character decoder.
// ---------------------------------------------------------------------------
package scdec_pkg;

  localparam int unsigned CodeW = 8;

  typedef logic [CodeW-1:0] byte_t;

  // Keyboard state flags carried between the top level and the decoder.
  typedef struct packed {
    logic ext_pending;
    logic shift_held;
    logic caps_on;
    logic ctrl_held;
    logic alt_held;
  } flags_t;

  // Scancodes with a meaning of their own.
  localparam byte_t PfxExt    = 8'hE0;
  localparam byte_t LShiftDn  = 8'h2A;
  localparam byte_t RShiftDn  = 8'h36;
  localparam byte_t LShiftUp  = 8'hAA;
  localparam byte_t RShiftUp  = 8'hB6;
  localparam byte_t CapsKey   = 8'h3A;
  localparam byte_t CtrlDn    = 8'h1D;
  localparam byte_t CtrlUp    = 8'h9D;
  localparam byte_t AltDn     = 8'h38;
  localparam byte_t AltUp     = 8'hB8;
  localparam int unsigned BreakBit = 7;

  // Extended navigation make codes.
  localparam byte_t ExtUp    = 8'h48;
  localparam byte_t ExtDown  = 8'h50;
  localparam byte_t ExtLeft  = 8'h4B;
  localparam byte_t ExtRight = 8'h4D;
  localparam byte_t ExtHome  = 8'h47;
  localparam byte_t ExtEnd   = 8'h4F;
  localparam byte_t ExtPgUp  = 8'h49;
  localparam byte_t ExtPgDn  = 8'h51;

  // Control codes given for the navigation keys.
  localparam byte_t NavUpCode    = 8'h0B;
  localparam byte_t NavDownCode  = 8'h0C;
  localparam byte_t NavLeftCode  = 8'h10;
  localparam byte_t NavRightCode = 8'h14;
  localparam byte_t NavHomeCode  = 8'h01;
  localparam byte_t NavEndCode   = 8'h05;
  localparam byte_t NavPgUpCode  = 8'h02;
  localparam byte_t NavPgDnCode  = 8'h06;

  localparam byte_t CtrlBand = 8'h80;
  localparam byte_t AltBand  = 8'hE0;

  localparam byte_t ChLowA  = 8'h61;
  localparam byte_t ChLowZ  = 8'h7A;
  localparam byte_t ChUpA   = 8'h41;
  localparam byte_t ChUpZ   = 8'h5A;
  localparam byte_t CaseGap = 8'h20;

  function automatic byte_t nav_code(input byte_t b);
    byte_t c;
    c = '0;
    unique case (b)
      ExtUp:    c = NavUpCode;
      ExtDown:  c = NavDownCode;
      ExtLeft:  c = NavLeftCode;
      ExtRight: c = NavRightCode;
      ExtHome:  c = NavHomeCode;
      ExtEnd:   c = NavEndCode;
      ExtPgUp:  c = NavPgUpCode;
      ExtPgDn:  c = NavPgDnCode;
      default:  c = '0;
    endcase
    return c;
  endfunction

  // Keys that read the same with and without shift, keypad included.
  function automatic byte_t common_char(input logic [6:0] idx);
    byte_t c;
    c = '0;
    unique case (idx)
      7'h0E: c = 8'h08;
      7'h0F: c = 8'h09;
      7'h1C: c = 8'h0A;
      7'h37: c = 8'h2A;
      7'h39: c = 8'h20;
      7'h47: c = 8'h37;
      7'h48: c = 8'h38;
      7'h49: c = 8'h39;
      7'h4A: c = 8'h2D;
      7'h4B: c = 8'h34;
      7'h4C: c = 8'h35;
      7'h4D: c = 8'h36;
      7'h4E: c = 8'h2B;
      7'h4F: c = 8'h31;
      7'h50: c = 8'h32;
      7'h51: c = 8'h33;
      7'h52: c = 8'h30;
      7'h53: c = 8'h2E;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic byte_t plain_char(input logic [6:0] idx);
    byte_t c;
    c = common_char(idx);
    unique case (idx)
      7'h02: c = 8'h31;
      7'h03: c = 8'h32;
      7'h04: c = 8'h33;
      7'h05: c = 8'h34;
      7'h06: c = 8'h35;
      7'h07: c = 8'h36;
      7'h08: c = 8'h37;
      7'h09: c = 8'h38;
      7'h0A: c = 8'h39;
      7'h0B: c = 8'h30;
      7'h0C: c = 8'h2D;
      7'h0D: c = 8'h3D;
      7'h10: c = 8'h71;
      7'h11: c = 8'h77;
      7'h12: c = 8'h65;
      7'h13: c = 8'h72;
      7'h14: c = 8'h74;
      7'h15: c = 8'h79;
      7'h16: c = 8'h75;
      7'h17: c = 8'h69;
      7'h18: c = 8'h6F;
      7'h19: c = 8'h70;
      7'h1A: c = 8'h5B;
      7'h1B: c = 8'h5D;
      7'h1E: c = 8'h61;
      7'h1F: c = 8'h73;
      7'h20: c = 8'h64;
      7'h21: c = 8'h66;
      7'h22: c = 8'h67;
      7'h23: c = 8'h68;
      7'h24: c = 8'h6A;
      7'h25: c = 8'h6B;
      7'h26: c = 8'h6C;
      7'h27: c = 8'h3B;
      7'h28: c = 8'h27;
      7'h29: c = 8'h60;
      7'h2B: c = 8'h5C;
      7'h2C: c = 8'h7A;
      7'h2D: c = 8'h78;
      7'h2E: c = 8'h63;
      7'h2F: c = 8'h76;
      7'h30: c = 8'h62;
      7'h31: c = 8'h6E;
      7'h32: c = 8'h6D;
      7'h33: c = 8'h2C;
      7'h34: c = 8'h2E;
      7'h35: c = 8'h2F;
      default: ;
    endcase
    return c;
  endfunction

  function automatic byte_t shifted_char(input logic [6:0] idx);
    byte_t c;
    byte_t p;
    c = common_char(idx);
    p = plain_char(idx);
    // Letters simply move to upper case.
    if (p >= ChLowA && p <= ChLowZ) c = p - CaseGap;
    unique case (idx)
      7'h02: c = 8'h21;
      7'h03: c = 8'h40;
      7'h04: c = 8'h23;
      7'h05: c = 8'h24;
      7'h06: c = 8'h25;
      7'h07: c = 8'h5E;
      7'h08: c = 8'h26;
      7'h09: c = 8'h2A;
      7'h0A: c = 8'h28;
      7'h0B: c = 8'h29;
      7'h0C: c = 8'h5F;
      7'h0D: c = 8'h2B;
      7'h1A: c = 8'h7B;
      7'h1B: c = 8'h7D;
      7'h27: c = 8'h3A;
      7'h28: c = 8'h22;
      7'h29: c = 8'h7E;
      7'h2B: c = 8'h7C;
      7'h33: c = 8'h3C;
      7'h34: c = 8'h3E;
      7'h35: c = 8'h3F;
      default: ;
    endcase
    return c;
  endfunction

  // Ctrl band encoding; zero means the key is dropped.
  function automatic byte_t ctrl_code(input byte_t c);
    byte_t r;
    r = '0;
    if ((c >= ChLowA && c <= ChLowZ) || (c >= ChUpA && c <= ChUpZ)) begin
      r = CtrlBand | {3'b000, c[4:0]};
    end else begin
      unique case (c)
        8'h5B:               r = CtrlBand | 8'd27;
        8'h5C:               r = CtrlBand | 8'd28;
        8'h5D:               r = CtrlBand | 8'd29;
        8'h36, 8'h5E:        r = CtrlBand | 8'd30;
        8'h2D, 8'h5F:        r = CtrlBand | 8'd31;
        8'h20, 8'h40, 8'h32: r = CtrlBand;
        default:             r = '0;
      endcase
    end
    return r;
  endfunction

endpackage

// ===== rtl/scdec_decode.sv =====
// ---------------------------------------------------------------------------
// Scancode decode logic
// Combinational decode of one scancode against the current keyboard flags:
// gives the next flags and at most one character.
// ---------------------------------------------------------------------------
module scdec_decode (
  input  scdec_pkg::byte_t  scan_code_i,
  input  scdec_pkg::flags_t flags_i,
  output scdec_pkg::flags_t flags_o,
  output logic              char_valid_o,
  output scdec_pkg::byte_t  char_code_o
);

  scdec_pkg::byte_t base_char;
  scdec_pkg::byte_t case_char;
  scdec_pkg::byte_t mod_char;
  scdec_pkg::byte_t nav_char;
  logic             is_lower;

  assign base_char = flags_i.shift_held ? scdec_pkg::shifted_char(scan_code_i[6:0])
                                        : scdec_pkg::plain_char(scan_code_i[6:0]);
  assign is_lower  = (base_char >= scdec_pkg::ChLowA) && (base_char <= scdec_pkg::ChLowZ);
  assign case_char = (flags_i.caps_on && is_lower) ? base_char - scdec_pkg::CaseGap
                                                   : base_char;
  assign nav_char  = scdec_pkg::nav_code(scan_code_i);

  always_comb begin
    if (flags_i.ctrl_held) begin
      mod_char = scdec_pkg::ctrl_code(case_char);
    end else if (flags_i.alt_held && case_char >= scdec_pkg::ChLowA &&
                 case_char <= scdec_pkg::ChLowZ) begin
      mod_char = scdec_pkg::AltBand | {3'b000, case_char[4:0]};
    end else begin
      mod_char = case_char;
    end
  end

  always_comb begin
    flags_o      = flags_i;
    char_valid_o = 1'b0;
    char_code_o  = mod_char;
    priority if (scan_code_i == scdec_pkg::PfxExt) begin
      flags_o.ext_pending = 1'b1;
    end else if (flags_i.ext_pending) begin
      flags_o.ext_pending = 1'b0;
      char_code_o         = nav_char;
      char_valid_o        = !scan_code_i[scdec_pkg::BreakBit] && (nav_char != '0);
    end else if (scan_code_i == scdec_pkg::LShiftDn || scan_code_i == scdec_pkg::RShiftDn) begin
      flags_o.shift_held = 1'b1;
    end else if (scan_code_i == scdec_pkg::LShiftUp || scan_code_i == scdec_pkg::RShiftUp) begin
      flags_o.shift_held = 1'b0;
    end else if (scan_code_i == scdec_pkg::CapsKey) begin
      flags_o.caps_on = !flags_i.caps_on;
    end else if (scan_code_i == scdec_pkg::CtrlDn) begin
      flags_o.ctrl_held = 1'b1;
    end else if (scan_code_i == scdec_pkg::CtrlUp) begin
      flags_o.ctrl_held = 1'b0;
    end else if (scan_code_i == scdec_pkg::AltDn) begin
      flags_o.alt_held = 1'b1;
    end else if (scan_code_i == scdec_pkg::AltUp) begin
      flags_o.alt_held = 1'b0;
    end else begin
      char_valid_o = !scan_code_i[scdec_pkg::BreakBit] && (mod_char != '0);
    end
  end

endmodule

// ===== rtl/scancode_set1_to_char_decoder_top.sv =====
// ---------------------------------------------------------------------------
// Set-1 scancode to character decoder
// Turns a stream of keyboard scancode bytes into US layout character bytes.
// ---------------------------------------------------------------------------
// One scancode is taken per transfer on the slave side and yields zero or one
// character on the master side. Each scancode is decoded in the cycle it is
// taken, so a new scancode can be taken every cycle unless the input stalls.
// A character goes to the output register, or to the skid register while the
// output register holds one not yet taken. These two entries let the input
// flow while a character waits; it stalls only when both are full. Modifier
// and prefix codes update key flags; they and break codes give no character.
module scancode_set1_to_char_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] scan_code
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [7:0] char_code
);

  scdec_pkg::flags_t flags_q, flags_d;
  logic              out_valid_q, out_valid_d;
  scdec_pkg::byte_t  out_data_q, out_data_d;
  logic              skid_valid_q, skid_valid_d;
  scdec_pkg::byte_t  skid_data_q, skid_data_d;

  logic              in_fire;
  logic              out_fire;
  logic              res_valid;
  scdec_pkg::byte_t  res_code;
  scdec_pkg::flags_t dec_flags;

  scdec_decode u_decode (
    .scan_code_i  (s_axis_tdata),
    .flags_i      (flags_q),
    .flags_o      (dec_flags),
    .char_valid_o (res_valid),
    .char_code_o  (res_code)
  );

  assign s_axis_tready = !skid_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = out_valid_q && m_axis_tready;

  always_comb begin
    flags_d      = in_fire ? dec_flags : flags_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || out_fire) begin
      // Output slot frees up: drain the skid entry first, else take the new result.
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = in_fire && res_valid;
        out_data_d  = res_code;
      end
    end else if (in_fire && res_valid) begin
      skid_valid_d = 1'b1;
      skid_data_d  = res_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q      <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      flags_q      <= flags_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

endmodule
